[rtl/fta_pkg.sv]
// Shared types and constants for the flow totalizer with limit alarm.
// Used by the averager, the accumulator and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fta_pkg;

    localparam int BLOCK_SAMPLES_DEF = 10;
    localparam int LIMIT_RESET_DEF   = 100;
    localparam int TOTAL_BITS_DEF    = 32;

    localparam logic [7:0] KEY_UP     = 8'hC0;
    localparam logic [7:0] KEY_DOWN   = 8'hC8;
    localparam logic [7:0] KEY_CLEAR  = 8'hC1;
    localparam logic [7:0] KEY_PAUSE  = 8'hC9;
    localparam logic [7:0] LIMIT_STEP = 8'd10;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_KEY    = 2'd2
    } op_t;

    typedef struct packed {
        op_t        operation;
        logic [7:0] adc_sample;
        logic [7:0] key_code;
    } ev_t;

    typedef struct packed {
        logic [7:0] average;
        logic       fresh;
    } avg_t;

    typedef struct packed {
        logic [7:0] limit;
        logic       alarm;
        logic       paused;
    } acc_t;

endpackage

`default_nettype wire

[rtl/flow_totalizer_with_limit_alarm.sv]
// Top level of the flow totalizer: input register, averager, accumulator
// and result register. Depends on fta_pkg, fta_avg and fta_acc.
//
//  channel  direction  tdata                                   tuser
//  s_*      in         adc_sample[7:0], key_code[15:8]         operation[1:0]
//  m_*      out        instant_flow, total_flow, flow_limit,   new_average[0]
//                      alarm, paused (see port comment)
//
// Each word passes from the input register straight to the result register;
// one word is taken every cycle while the result register is not stalled.
// The rate is set by the single state update between the two registers.
// Reset clears all state; the limit returns to LIMIT_RESET.
// A stalled result holds while the input register still takes one word.
`timescale 1ns / 1ps
`default_nettype none

module flow_totalizer_with_limit_alarm #(
    parameter int BLOCK_SAMPLES = fta_pkg::BLOCK_SAMPLES_DEF,
    parameter int LIMIT_RESET   = fta_pkg::LIMIT_RESET_DEF,
    parameter int TOTAL_BITS    = fta_pkg::TOTAL_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // adc_sample[7:0], key_code[15:8]
    input  wire logic [1:0]  s_tuser,  // operation[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // instant_flow[7:0], total_flow[39:8], flow_limit[47:40], alarm[48],
    // paused[49], zero[55:50]
    output logic [55:0]      m_tdata,
    output logic [0:0]       m_tuser   // new_average[0]
);
    import fta_pkg::*;

    localparam int WIDE_W = (TOTAL_BITS > 32) ? TOTAL_BITS : 32;

    logic                  in_valid_reg;
    ev_t                   ev_reg;
    logic                  advance;
    logic                  paused_now;
    avg_t                  avg_status;
    acc_t                  acc_status;
    logic [TOTAL_BITS-1:0] total_next;
    logic [WIDE_W-1:0]     total_wide;

    logic                  out_valid_reg;
    logic [7:0]            flow_reg;
    logic                  fresh_reg;
    logic [31:0]           total_reg;
    logic [7:0]            limit_reg;
    logic                  alarm_reg;
    logic                  paused_reg;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            ev_reg.operation  <= op_t'(s_tuser);
            ev_reg.adc_sample <= s_tdata[7:0];
            ev_reg.key_code   <= s_tdata[15:8];
        end
    end

    fta_avg #(
        .BLOCK_SAMPLES(BLOCK_SAMPLES)
    ) u_avg (
        .clk    (clk),
        .rst_n  (rst_n),
        .advance(advance),
        .ev     (ev_reg),
        .paused (paused_now),
        .status (avg_status)
    );

    fta_acc #(
        .LIMIT_RESET(LIMIT_RESET),
        .TOTAL_BITS (TOTAL_BITS)
    ) u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .ev        (ev_reg),
        .average   (avg_status.average),
        .paused_now(paused_now),
        .total_next(total_next),
        .status    (acc_status)
    );

    assign total_wide = WIDE_W'(total_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            flow_reg      <= '0;
            fresh_reg     <= 1'b0;
            total_reg     <= '0;
            limit_reg     <= '0;
            alarm_reg     <= 1'b0;
            paused_reg    <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
            flow_reg      <= avg_status.average;
            fresh_reg     <= avg_status.fresh;
            total_reg     <= total_wide[31:0];
            limit_reg     <= acc_status.limit;
            alarm_reg     <= acc_status.alarm;
            paused_reg    <= acc_status.paused;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, paused_reg, alarm_reg, limit_reg, total_reg, flow_reg};
    assign m_tuser  = fresh_reg;

    a_advance_fills : assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("result register not loaded after a word was processed");

    a_alarm_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        alarm_reg |=> alarm_reg)
        else $error("latched alarm was released");

    a_fresh_sample : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && avg_status.fresh) |-> (ev_reg.operation == OP_SAMPLE && !paused_now))
        else $error("block average completed by a word that is not a live sample");

    a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

[rtl/fta_avg.sv]
// Block averager: sums samples in blocks and forms the floor average.
// Depends on fta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fta_avg #(
    parameter int BLOCK_SAMPLES = fta_pkg::BLOCK_SAMPLES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         advance,
    input  wire fta_pkg::ev_t ev,
    input  wire logic         paused,
    output fta_pkg::avg_t     status
);
    import fta_pkg::*;

    localparam int CNT_W  = $clog2(BLOCK_SAMPLES);
    localparam int SUM_W  = $clog2(BLOCK_SAMPLES * 255 + 1);
    localparam int SHIFT  = SUM_W + $clog2(BLOCK_SAMPLES);
    localparam int PROD_W = SUM_W + SHIFT + 1;
    localparam logic [SHIFT:0] RECIP =
        (SHIFT + 1)'(((1 << SHIFT) + BLOCK_SAMPLES - 1) / BLOCK_SAMPLES);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next, sum_add;
    logic [7:0]        average_reg, average_next;
    logic [PROD_W-1:0] product;
    logic              take;
    logic              block_done;

    // The ceiling reciprocal with this shift gives the exact floor quotient
    // for every sum the block can reach.
    assign take       = (ev.operation == OP_SAMPLE) && !paused;
    assign sum_add    = sum_reg + SUM_W'(ev.adc_sample);
    assign block_done = (count_reg == CNT_W'(BLOCK_SAMPLES - 1));
    assign product    = PROD_W'(sum_add) * PROD_W'(RECIP);

    always_comb
    begin
        count_next   = count_reg;
        sum_next     = sum_reg;
        average_next = average_reg;
        if (take)
        begin
            if (block_done)
            begin
                count_next   = '0;
                sum_next     = '0;
                average_next = product[SHIFT +: 8];
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
                sum_next   = sum_add;
            end
        end
    end

    assign status.average = average_next;
    assign status.fresh   = take && block_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            sum_reg     <= '0;
            average_reg <= '0;
        end
        else if (advance)
        begin
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            average_reg <= average_next;
        end
    end

endmodule

`default_nettype wire

[rtl/fta_acc.sv]
// Accumulator: saturating flow total, limit keys, pause and the latched alarm.
// Depends on fta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fta_acc #(
    parameter int LIMIT_RESET = fta_pkg::LIMIT_RESET_DEF,
    parameter int TOTAL_BITS  = fta_pkg::TOTAL_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  advance,
    input  wire fta_pkg::ev_t          ev,
    input  wire logic [7:0]            average,
    output logic                       paused_now,
    output logic [TOTAL_BITS-1:0]      total_next,
    output fta_pkg::acc_t              status
);
    import fta_pkg::*;

    localparam int CMP_W = TOTAL_BITS + 3;

    logic [TOTAL_BITS-1:0] total_reg, total_sat;
    logic [TOTAL_BITS:0]   total_sum;
    logic [7:0]            limit_reg, limit_next;
    logic                  alarm_reg, alarm_next;
    logic                  pause_reg, pause_next;
    logic [CMP_W-1:0]      total_x5, limit_x256;
    logic                  over;

    assign total_sum = {1'b0, total_reg} + (TOTAL_BITS + 1)'(average);
    assign total_sat = total_sum[TOTAL_BITS] ? '1 : total_sum[TOTAL_BITS-1:0];

    always_comb
    begin
        total_next = total_reg;
        limit_next = limit_reg;
        pause_next = pause_reg;
        unique case (ev.operation)
            OP_SAMPLE:
            begin
            end
            OP_TICK:
            begin
                if (!pause_reg)
                begin
                    total_next = total_sat;
                end
            end
            OP_KEY:
            begin
                unique case (ev.key_code)
                    KEY_UP:    limit_next = limit_reg + LIMIT_STEP;
                    KEY_DOWN:  limit_next = limit_reg - LIMIT_STEP;
                    KEY_CLEAR: total_next = '0;
                    KEY_PAUSE: pause_next = !pause_reg;
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // The total counts 5/256 cc, so total*5 > limit*256 compares in cc.
    assign total_x5   = (CMP_W'(total_next) << 2) + CMP_W'(total_next);
    assign limit_x256 = CMP_W'({limit_next, 8'h00});
    assign over       = total_x5 > limit_x256;
    assign alarm_next = alarm_reg || (!pause_next && over);

    assign paused_now    = pause_reg;
    assign status.limit  = limit_next;
    assign status.alarm  = alarm_next;
    assign status.paused = pause_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            limit_reg <= 8'(LIMIT_RESET);
            alarm_reg <= 1'b0;
            pause_reg <= 1'b0;
        end
        else if (advance)
        begin
            total_reg <= total_next;
            limit_reg <= limit_next;
            alarm_reg <= alarm_next;
            pause_reg <= pause_next;
        end
    end

endmodule

`default_nettype wire

[dv/flow_totalizer_with_limit_alarm_tb.sv]
// Self-checking testbench for the flow totalizer with limit alarm.
// Drives event words with random gaps and back-pressure, predicts each result
// word in step with the stream and compares it. Depends on fta_pkg and the DUT.
`timescale 1ns / 1ps

module flow_totalizer_with_limit_alarm_tb;
    import fta_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         RANDOM_WORDS = 800;

    typedef struct packed {
        logic [7:0]  flow;
        logic        fresh;
        logic [31:0] total;
        logic [7:0]  limit;
        logic        alarm;
        logic        paused;
    } flow_report_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;  // adc_sample[7:0], key_code[15:8]
    logic [1:0]  s_tuser;  // operation[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // instant_flow[7:0], total_flow[39:8], flow_limit[47:40], alarm[48],
    // paused[49], zero[55:50]
    logic [55:0] m_tdata;
    logic [0:0]  m_tuser;  // new_average[0]

    int          blk_count;
    logic [11:0] blk_sum;
    logic [7:0]  cur_avg;
    logic [31:0] run_total;
    logic [7:0]  flow_lim;
    logic        alarm_set;
    logic        hold_state;

    flow_report_t pending_reports[$];
    int           mismatches = 0;
    int           cycles = 0;
    int           stall_left = 0;
    logic         calm = 1'b0;

    flow_totalizer_with_limit_alarm dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void reset_totalizer();
        blk_count  = 0;
        blk_sum    = '0;
        cur_avg    = '0;
        run_total  = '0;
        flow_lim   = 8'(LIMIT_RESET_DEF);
        alarm_set  = 1'b0;
        hold_state = 1'b0;
    endfunction

    function automatic flow_report_t apply_event(logic [1:0] op, logic [7:0] sample,
                                                 logic [7:0] key);
        flow_report_t      r;
        logic              fresh;
        logic [32:0]       sum_t;
        longint unsigned   total_cc;
        longint unsigned   limit_cc;
        fresh = 1'b0;
        case (op)
            OP_SAMPLE:
                if (!hold_state)
                begin
                    blk_sum = blk_sum + 12'(sample);
                    blk_count++;
                    if (blk_count >= BLOCK_SAMPLES_DEF)
                    begin
                        cur_avg   = 8'(blk_sum / BLOCK_SAMPLES_DEF);
                        blk_sum   = '0;
                        blk_count = 0;
                        fresh     = 1'b1;
                    end
                end
            OP_TICK:
                if (!hold_state)
                begin
                    sum_t     = {1'b0, run_total} + 33'(cur_avg);
                    run_total = sum_t[32] ? '1 : sum_t[31:0];
                end
            OP_KEY:
                case (key)
                    KEY_UP:    flow_lim = flow_lim + LIMIT_STEP;
                    KEY_DOWN:  flow_lim = flow_lim - LIMIT_STEP;
                    KEY_CLEAR: run_total = '0;
                    KEY_PAUSE: hold_state = !hold_state;
                    default:   ;
                endcase
            default: ;
        endcase
        total_cc = run_total;
        limit_cc = flow_lim;
        if (!hold_state && total_cc * 5 > limit_cc * 256)
            alarm_set = 1'b1;
        r.flow   = cur_avg;
        r.fresh  = fresh;
        r.total  = run_total;
        r.limit  = flow_lim;
        r.alarm  = alarm_set;
        r.paused = hold_state;
        return r;
    endfunction

    function automatic void check_field(string label, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", label, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        flow_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("result word with no event waiting for it");
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("instant_flow", want.flow, m_tdata[7:0]);
                check_field("new_average", want.fresh, m_tuser[0]);
                check_field("total_flow", want.total, m_tdata[39:8]);
                check_field("flow_limit", want.limit, m_tdata[47:40]);
                check_field("alarm", want.alarm, m_tdata[48]);
                check_field("paused", want.paused, m_tdata[49]);
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 25)
                stall_left <= pick_gap();
        end
    end

    task automatic send_event(input logic [1:0] op, input logic [7:0] sample,
                              input logic [7:0] key);
        int gap;
        gap = pick_gap();
        repeat (gap) @(negedge clk) s_tvalid <= 1'b0;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {key, sample};
        do
            @(posedge clk);
        while (!s_tready);
        pending_reports.push_back(apply_event(op, sample, key));
    endtask

    task automatic wait_for_results();
        @(negedge clk) s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_ignored_events();
        send_event(OP_UNUSED, 8'($urandom), 8'($urandom));
        send_event(OP_KEY, 8'h00, 8'hFF);
        send_event(OP_KEY, 8'hFF, 8'h00);
    endtask

    task automatic test_block_average();
        repeat (BLOCK_SAMPLES_DEF - 1) send_event(OP_SAMPLE, 8'hFF, 8'h00);
        send_event(OP_SAMPLE, 8'h00, 8'hFF);
        send_event(OP_TICK, 8'h00, 8'h00);
    endtask

    task automatic test_pause_holds_alarm();
        repeat (2) send_event(OP_TICK, 8'h00, 8'h00);
        send_event(OP_KEY, 8'h00, KEY_PAUSE);
        repeat (9) send_event(OP_KEY, 8'h00, KEY_DOWN);
        send_event(OP_SAMPLE, 8'h80, 8'h00);
        send_event(OP_TICK, 8'h00, 8'h00);
        send_event(OP_KEY, 8'h00, KEY_PAUSE);
        send_event(OP_KEY, 8'h00, KEY_CLEAR);
        send_event(OP_KEY, 8'h00, KEY_UP);
    endtask

    task automatic test_random_events();
        int         counted;
        int         r;
        logic [1:0] op;
        logic [7:0] key;
        counted = 0;
        while (counted < RANDOM_WORDS)
        begin
            calm = ((counted / 100) % 4 == 3);
            if (counted == RANDOM_WORDS / 2)
                wait_for_results();
            r = $urandom_range(0, 99);
            if (r < 50)
                op = OP_SAMPLE;
            else if (r < 72)
                op = OP_TICK;
            else if (r < 95)
                op = OP_KEY;
            else
                op = OP_UNUSED;
            case ($urandom_range(0, 9))
                0, 1:    key = KEY_UP;
                2, 3:    key = KEY_DOWN;
                4:       key = KEY_CLEAR;
                5:       key = KEY_PAUSE;
                default: key = 8'($urandom);
            endcase
            send_event(op, 8'($urandom), key);
            counted++;
        end
        calm = 1'b0;
    endtask

    initial
    begin
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        rst_n    = 1'b0;
        reset_totalizer();
        repeat (5) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_ignored_events();
        test_block_average();
        test_pause_holds_alarm();
        test_random_events();

        wait_for_results();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
rtl/fta_pkg.sv
rtl/fta_avg.sv
rtl/fta_acc.sv
rtl/flow_totalizer_with_limit_alarm.sv
dv/flow_totalizer_with_limit_alarm_tb.sv
